// ===== rtl/polyline_path_follower_defines.svh =====
// assertion macros for the polyline path follower
// no dependencies
`ifndef POLYLINE_PATH_FOLLOWER_DEFINES_SVH
`define POLYLINE_PATH_FOLLOWER_DEFINES_SVH
`define PPF_ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("ppf check failed");
`define PPF_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("ppf check failed");
`endif

// ===== rtl/ppf_pkg.sv =====
// types and constants of the polyline path follower
// no dependencies
package ppf_pkg;
  localparam int MaxPoints = 64;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = AddrW + 1;
  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_SPEED = 2'd1;
  localparam logic [1:0] CFG_ORGX = 2'd2;
  localparam logic [1:0] CFG_ORGY = 2'd3;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  typedef struct packed {
    logic func;
    logic [5:0] point_index;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } in_word_t;
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic finished;
  } out_word_t;
endpackage

// ===== rtl/ppf_ram.sv =====
// generic single port ram with registered read
// no dependencies
module ppf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/polyline_path_follower.sv =====
// polyline path follower: a tick walks the path from the first vertex through one shared unit
// a tick accepted when already finished goes straight to output; otherwise each segment is read,
// measured by square root and skipped until the distance falls inside one or the path ends,
// then divided per axis; a new word is taken only while idle; no stall
// reset (synchronous, rst_n low) clears progress, finished flag and registers, not vertices
// depends on ppf_pkg, ppf_ram, polyline_path_follower_defines.svh
`include "polyline_path_follower_defines.svh"
module polyline_path_follower (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  ppf_pkg::in_word_t in_word,
  output logic out_valid,
  output ppf_pkg::out_word_t out_word,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_wdata
);
  import ppf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001, S_RD0 = 11'b00000000010, S_RD1 = 11'b00000000100,
    S_SQ = 11'b00000001000, S_SQRT = 11'b00000010000, S_CMP = 11'b00000100000,
    S_MUL = 11'b00001000000, S_DIV = 11'b00010000000, S_OUT = 11'b00100000000,
    S_LOAD = 11'b01000000000, S_FIN = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] count_r;
  logic [15:0] speed_r;
  logic signed [23:0] orgx_r, orgy_r;
  logic [31:0] trav_r;
  logic done_r;
  logic [AddrW-1:0] seg_r;
  logic [CntW-1:0] n_eff;
  logic signed [24:0] dx_r, dy_r;
  logic signed [23:0] sx_r, sy_r;
  logic [49:0] sq_r;
  logic [31:0] rem_r;
  logic [24:0] len_r;
  logic [1:0] step_r;
  logic [5:0] it_r;
  logic [49:0] sv_r;
  logic [49:0] sr_r;
  logic [56:0] dnum_r;
  logic [56:0] dq_r;
  logic [24:0] drm_r;
  logic axis_r;
  logic signed [25:0] px_r, py_r;
  logic [AddrW-1:0] ram_addr;
  logic ram_we;
  logic [47:0] ram_rd;
  logic [25:0] drm_sh;
  logic [24:0] mag;

  ppf_ram #(.Width(48), .Depth(MaxPoints)) u_vram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata({in_word.point_x, in_word.point_y}), .rdata(ram_rd)
  );

  assign n_eff = (count_r > CntW'(MaxPoints)) ? CntW'(MaxPoints) : count_r;
  assign busy = (state_r != S_IDLE);
  assign ram_we = (state_r == S_IDLE) && start && (in_word.func == FUNC_LOAD)
    && ({1'b0, in_word.point_index} < 7'(MaxPoints));
  assign ram_addr = (state_r == S_IDLE) ? in_word.point_index[AddrW-1:0]
    : ((state_r == S_RD0) ? seg_r : seg_r + 1'b1);
  assign drm_sh = {drm_r, dnum_r[56]};
  assign mag = axis_r ? (dy_r[24] ? -dy_r : dy_r) : (dx_r[24] ? -dx_r : dx_r);

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) return 24'sh7fffff;
    if (v < -27'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = (in_word.func == FUNC_LOAD) ? S_LOAD
        : ((n_eff == '0) ? S_IDLE : (done_r ? S_OUT : S_FIN));
      S_FIN: state_nxt = (n_eff < CntW'(2)) ? S_OUT : S_RD0;
      S_RD0: state_nxt = S_RD1;
      S_RD1: state_nxt = S_SQ;
      S_SQ: if (step_r == 2'd3) state_nxt = S_SQRT;
      S_SQRT: if (it_r == 6'd23) state_nxt = S_CMP;
      S_CMP: state_nxt = S_MUL;
      S_MUL: state_nxt = (33'(rem_r) < 33'(len_r)) ? S_DIV
        : ((32'(seg_r) + 32'd2 < 32'(n_eff)) ? S_RD0 : S_OUT);
      S_DIV: if (it_r == 6'd56) state_nxt = axis_r ? S_OUT : S_MUL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0; speed_r <= '0; orgx_r <= '0; orgy_r <= '0;
      trav_r <= '0; done_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_OUT);
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNT: count_r <= cfg_wdata[CntW-1:0];
          CFG_SPEED: speed_r <= cfg_wdata[15:0];
          CFG_ORGX: orgx_r <= cfg_wdata;
          CFG_ORGY: orgy_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          seg_r <= '0;
          if (start && in_word.func == FUNC_LOAD) begin
            trav_r <= '0; done_r <= 1'b0;
          end
        end
        S_FIN: begin
          trav_r <= (33'(trav_r) + 33'(speed_r) > 33'hffffffff) ? 32'hffffffff
            : trav_r + 32'(speed_r);
          rem_r <= (33'(trav_r) + 33'(speed_r) > 33'hffffffff) ? 32'hffffffff
            : trav_r + 32'(speed_r);
          done_r <= 1'b1;
        end
        S_RD1: begin
          sx_r <= ram_rd[47:24]; sy_r <= ram_rd[23:0];
          step_r <= '0;
        end
        S_SQ: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            2'd0: begin
              dx_r <= 25'(signed'(ram_rd[47:24])) - 25'(sx_r);
              dy_r <= 25'(signed'(ram_rd[23:0])) - 25'(sy_r);
            end
            2'd1: sq_r <= 50'(dx_r * dx_r);
            2'd2: sq_r <= sq_r + 50'(dy_r * dy_r);
            default: begin
              sv_r <= sq_r; sr_r <= '0; sq_r <= 50'd1 << 48; it_r <= '0;
            end
          endcase
        end
        S_SQRT: begin
          it_r <= it_r + 1'b1;
          if (sv_r >= sr_r + sq_r) begin
            sv_r <= sv_r - (sr_r + sq_r);
            sr_r <= (sr_r >> 1) + sq_r;
          end else begin
            sr_r <= sr_r >> 1;
          end
          sq_r <= sq_r >> 2;
        end
        S_CMP: begin
          len_r <= (sv_r >= sr_r + sq_r) ? 25'((sr_r >> 1) + sq_r) : 25'(sr_r >> 1);
          axis_r <= 1'b0;
        end
        S_MUL: begin
          if (33'(rem_r) < 33'(len_r)) begin
            dnum_r <= 57'(mag) * 57'(rem_r);
            dq_r <= '0; drm_r <= '0; it_r <= '0;
            done_r <= 1'b0;
          end else begin
            rem_r <= rem_r - 32'(len_r);
            seg_r <= seg_r + 1'b1;
          end
        end
        S_DIV: begin
          it_r <= it_r + 1'b1;
          dnum_r <= dnum_r << 1;
          if (drm_sh >= 26'(len_r)) begin
            drm_r <= 25'(drm_sh - 26'(len_r)); dq_r <= {dq_r[55:0], 1'b1};
          end else begin
            drm_r <= drm_sh[24:0]; dq_r <= {dq_r[55:0], 1'b0};
          end
          if (it_r == 6'd56) begin
            axis_r <= 1'b1;
            if (!axis_r) px_r <= dx_r[24] ? 26'(sx_r) - 26'({dq_r[24:0], drm_sh >= 26'(len_r)})
              : 26'(sx_r) + 26'({dq_r[24:0], drm_sh >= 26'(len_r)});
            else py_r <= dy_r[24] ? 26'(sy_r) - 26'({dq_r[24:0], drm_sh >= 26'(len_r)})
              : 26'(sy_r) + 26'({dq_r[24:0], drm_sh >= 26'(len_r)});
          end
        end
        S_OUT: begin
          out_word.finished <= done_r;
          out_word.pos_x <= done_r ? orgx_r : sat24(27'(px_r) + 27'(orgx_r));
          out_word.pos_y <= done_r ? orgy_r : sat24(27'(py_r) + 27'(orgy_r));
        end
        default: ;
      endcase
    end
  end

  `PPF_ASSERT_NEXT(a_out_pulse, out_valid, !out_valid)
  `PPF_ASSERT_IMPL(a_busy_out, out_valid, !busy)
  `PPF_ASSERT_NEXT(a_load_clear, start && !busy && in_word.func == FUNC_LOAD, trav_r == '0)
endmodule
